>>> hw/rtl/vdt_pkg.sv
`timescale 1ns / 1ps

package vdt_pkg;

    localparam int DOTS_PER_LINE   = 341;
    localparam int LINES_PER_FRAME = 262;

    localparam int LINE_W = 10;
    localparam int DOT_W  = 9;

    // line numbers, -1 is the pre-render line
    localparam logic signed [LINE_W-1:0] LINE_PRE      = -10'sd1;
    localparam logic signed [LINE_W-1:0] LINE_FIRST    = 10'sd0;
    localparam logic signed [LINE_W-1:0] LINE_VIS_LAST = 10'sd239;
    localparam logic signed [LINE_W-1:0] LINE_VBLANK   = 10'sd241;
    localparam logic signed [LINE_W-1:0] LINE_LAST     = LINE_W'(LINES_PER_FRAME - 2);

    localparam logic [DOT_W-1:0] DOT_FIRST       = 9'd0;
    localparam logic [DOT_W-1:0] DOT_FLAG        = 9'd1;
    localparam logic [DOT_W-1:0] DOT_LEFT_LAST   = 9'd8;
    localparam logic [DOT_W-1:0] DOT_PIX_LAST    = 9'd256;
    localparam logic [DOT_W-1:0] DOT_COPY_X      = 9'd257;
    localparam logic [DOT_W-1:0] DOT_HOOK        = 9'd260;
    localparam logic [DOT_W-1:0] DOT_COPY_Y_LO   = 9'd280;
    localparam logic [DOT_W-1:0] DOT_COPY_Y_HI   = 9'd304;
    localparam logic [DOT_W-1:0] DOT_PREF_FIRST  = 9'd321;
    localparam logic [DOT_W-1:0] DOT_PREF_LAST   = 9'd336;
    localparam logic [DOT_W-1:0] DOT_SKIP        = 9'd339;
    localparam logic [DOT_W-1:0] DOT_LAST        = DOT_W'(DOTS_PER_LINE - 1);

    localparam logic [2:0] FETCH_NONE  = 3'd0;
    localparam logic [2:0] FETCH_SHIFT = 3'd1;
    localparam logic [2:0] FETCH_NAME  = 3'd2;
    localparam logic [2:0] FETCH_ATTR  = 3'd3;
    localparam logic [2:0] FETCH_PAT_LO = 3'd4;
    localparam logic [2:0] FETCH_PAT_HI = 3'd5;
    localparam logic [2:0] FETCH_LOAD  = 3'd6;

    localparam logic [2:0] SCROLL_NONE   = 3'd0;
    localparam logic [2:0] SCROLL_INC_Y  = 3'd1;
    localparam logic [2:0] SCROLL_COPY_X = 3'd2;
    localparam logic [2:0] SCROLL_COPY_Y = 3'd3;
    localparam logic [2:0] SCROLL_HOOK   = 3'd4;

    typedef struct packed {
        logic       bg_enable;
        logic       spr_enable;
        logic       bg_left_enable;
        logic       spr_left_enable;
        logic       nmi_enable;
        logic [1:0] bg_pixel;
        logic [1:0] bg_palette;
        logic [1:0] spr_pixel;
        logic [1:0] spr_palette;
        logic       spr_front;
        logic       spr_is_zero;
        logic       spr_zero_possible;
    } t_tick;

    typedef struct packed {
        logic       valid;
        logic [1:0] value;
        logic [1:0] palette;
        logic       from_sprite;
        logic       zero_hit;
    } t_pix;

    function automatic logic [2:0] fetch_code(input logic [2:0] phase);
        logic [2:0] code;
        unique case (phase)
            3'd1:    code = FETCH_NAME;
            3'd3:    code = FETCH_ATTR;
            3'd5:    code = FETCH_PAT_LO;
            3'd7:    code = FETCH_PAT_HI;
            3'd0:    code = FETCH_LOAD;
            default: code = FETCH_SHIFT;
        endcase
        return code;
    endfunction

endpackage

>>> hw/rtl/video_dot_timing_and_pixel_mux.sv
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// --------+-----------+--------------------+---------------------------------------
// tick    | in        | i_valid / o_stall  | enables, nmi enable, bg and sprite pixel
// result  | out       | o_valid / i_stall  | line, dot, pixel, flags, fetch, scroll
//
// one tick item per cycle while o_stall is low; a result passes through the input register, then the
// result register, with one pass of compose logic between them
// synchronous active-low reset: line -1, dot 0, even frame, flags clear, both stages empty
// a stalled result holds; the input side stalls only when both stages are full

module video_dot_timing_and_pixel_mux (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_bg_enable,
    input  logic                              i_spr_enable,
    input  logic                              i_bg_left_enable,
    input  logic                              i_spr_left_enable,
    input  logic                              i_nmi_enable,
    input  logic [1:0]                        i_bg_pixel,
    input  logic [1:0]                        i_bg_palette,
    input  logic [1:0]                        i_spr_pixel,
    input  logic [1:0]                        i_spr_palette,
    input  logic                              i_spr_front,
    input  logic                              i_spr_is_zero,
    input  logic                              i_spr_zero_possible,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [vdt_pkg::LINE_W-1:0] o_line,
    output logic [vdt_pkg::DOT_W-1:0]         o_dot,
    output logic                              o_pixel_valid,
    output logic [1:0]                        o_pixel_value,
    output logic [1:0]                        o_pixel_palette,
    output logic                              o_pixel_from_sprite,
    output logic                              o_vblank_flag,
    output logic                              o_sprite_zero_hit,
    output logic                              o_nmi_pulse,
    output logic                              o_frame_end,
    output logic [2:0]                        o_fetch_step,
    output logic [2:0]                        o_scroll_event
);

    // dot counters
    logic signed [vdt_pkg::LINE_W-1:0] r_line;
    logic [vdt_pkg::DOT_W-1:0]         r_dot;
    logic                              r_odd;

    // input stage
    logic                              r_s1_valid;
    vdt_pkg::t_tick                    r_s1_tick;
    logic signed [vdt_pkg::LINE_W-1:0] r_s1_line;
    logic [vdt_pkg::DOT_W-1:0]         r_s1_dot;
    logic                              r_s1_fend;

    // result stage
    logic                              r_o_valid;
    logic signed [vdt_pkg::LINE_W-1:0] r_o_line;
    logic [vdt_pkg::DOT_W-1:0]         r_o_dot;
    vdt_pkg::t_pix                     r_o_pix;
    logic                              r_vblank;
    logic                              r_zero_hit;
    logic                              r_o_nmi;
    logic                              r_o_fend;
    logic [2:0]                        r_o_fetch;
    logic [2:0]                        r_o_scroll;

    logic                              out_free;
    logic                              s1_free;
    logic                              in_acc;
    logic                              s1_move;
    logic                              in_render;
    logic signed [vdt_pkg::LINE_W-1:0] n_line;
    logic [vdt_pkg::DOT_W-1:0]         n_dot;
    logic                              n_odd;
    logic                              n_fend;

    logic                              s1_render;
    logic                              s1_pre;
    logic                              s1_vis;
    logic                              s1_fetch_dot;
    logic [2:0]                        n_fetch;
    logic [2:0]                        n_scroll;
    logic                              n_vblank;
    logic                              n_zero_hit;
    logic                              n_nmi;
    vdt_pkg::t_pix                     pix;

    assign out_free = !r_o_valid || !i_stall;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_stall  = !s1_free;
    assign in_acc   = i_valid && s1_free;
    assign s1_move  = r_s1_valid && out_free;

    assign in_render = i_bg_enable || i_spr_enable;

    // counter advance, with the short pre-render line on odd frames while rendering
    always_comb begin
        n_line = r_line;
        n_dot  = r_dot + 9'd1;
        n_odd  = r_odd;
        n_fend = 1'b0;
        priority if (r_line == vdt_pkg::LINE_PRE && r_dot == vdt_pkg::DOT_SKIP
                     && r_odd && in_render) begin
            n_line = vdt_pkg::LINE_FIRST;
            n_dot  = vdt_pkg::DOT_FIRST;
        end else if (r_dot == vdt_pkg::DOT_LAST) begin
            n_dot = vdt_pkg::DOT_FIRST;
            if (r_line == vdt_pkg::LINE_LAST) begin
                n_line = vdt_pkg::LINE_PRE;
                n_fend = 1'b1;
                n_odd  = !r_odd;
            end else begin
                n_line = r_line + 10'sd1;
            end
        end else begin
            n_dot = r_dot + 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= vdt_pkg::LINE_PRE;
            r_dot      <= vdt_pkg::DOT_FIRST;
            r_odd      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_line <= n_line;
                r_dot  <= n_dot;
                r_odd  <= n_odd;
            end
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_tick <= '{bg_enable: i_bg_enable, spr_enable: i_spr_enable,
                           bg_left_enable: i_bg_left_enable,
                           spr_left_enable: i_spr_left_enable,
                           nmi_enable: i_nmi_enable, bg_pixel: i_bg_pixel,
                           bg_palette: i_bg_palette, spr_pixel: i_spr_pixel,
                           spr_palette: i_spr_palette, spr_front: i_spr_front,
                           spr_is_zero: i_spr_is_zero,
                           spr_zero_possible: i_spr_zero_possible};
            r_s1_line <= r_line;
            r_s1_dot  <= r_dot;
            r_s1_fend <= n_fend;
        end
    end

    vdt_pixel_mux u_pixel_mux (
        .i_tick (r_s1_tick),
        .i_line (r_s1_line),
        .i_dot  (r_s1_dot),
        .o_pix  (pix)
    );

    assign s1_render    = r_s1_tick.bg_enable || r_s1_tick.spr_enable;
    assign s1_pre       = (r_s1_line == vdt_pkg::LINE_PRE);
    assign s1_vis       = (r_s1_line >= vdt_pkg::LINE_FIRST)
                        && (r_s1_line <= vdt_pkg::LINE_VIS_LAST);
    assign s1_fetch_dot = (r_s1_dot >= vdt_pkg::DOT_FLAG && r_s1_dot <= vdt_pkg::DOT_PIX_LAST)
                        || (r_s1_dot >= vdt_pkg::DOT_PREF_FIRST
                            && r_s1_dot <= vdt_pkg::DOT_PREF_LAST);

    always_comb begin
        n_fetch  = vdt_pkg::FETCH_NONE;
        n_scroll = vdt_pkg::SCROLL_NONE;
        if ((s1_pre || s1_vis) && s1_render) begin
            if (s1_fetch_dot) begin
                n_fetch = vdt_pkg::fetch_code(r_s1_dot[2:0]);
            end
            priority if (r_s1_dot == vdt_pkg::DOT_PIX_LAST) begin
                n_scroll = vdt_pkg::SCROLL_INC_Y;
            end else if (r_s1_dot == vdt_pkg::DOT_COPY_X) begin
                n_scroll = vdt_pkg::SCROLL_COPY_X;
            end else if (s1_pre && r_s1_dot >= vdt_pkg::DOT_COPY_Y_LO
                         && r_s1_dot <= vdt_pkg::DOT_COPY_Y_HI) begin
                n_scroll = vdt_pkg::SCROLL_COPY_Y;
            end else if (s1_vis && r_s1_dot == vdt_pkg::DOT_HOOK) begin
                n_scroll = vdt_pkg::SCROLL_HOOK;
            end else begin
                n_scroll = vdt_pkg::SCROLL_NONE;
            end
        end
    end

    always_comb begin
        n_vblank   = r_vblank;
        n_zero_hit = r_zero_hit;
        n_nmi      = 1'b0;
        if (s1_pre && r_s1_dot == vdt_pkg::DOT_FLAG) begin
            n_vblank   = 1'b0;
            n_zero_hit = 1'b0;
        end
        if (r_s1_line == vdt_pkg::LINE_VBLANK && r_s1_dot == vdt_pkg::DOT_FLAG) begin
            n_vblank = 1'b1;
            n_nmi    = r_s1_tick.nmi_enable;
        end
        if (pix.zero_hit) begin
            n_zero_hit = 1'b1;
        end
    end

    // status flags live in the result stage, so they move with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_vblank   <= 1'b0;
            r_zero_hit <= 1'b0;
        end else begin
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_vblank   <= n_vblank;
                r_zero_hit <= n_zero_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_line   <= r_s1_line;
            r_o_dot    <= r_s1_dot;
            r_o_pix    <= pix;
            r_o_nmi    <= n_nmi;
            r_o_fend   <= r_s1_fend;
            r_o_fetch  <= n_fetch;
            r_o_scroll <= n_scroll;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_line              = r_o_line;
    assign o_dot               = r_o_dot;
    assign o_pixel_valid       = r_o_pix.valid;
    assign o_pixel_value       = r_o_pix.value;
    assign o_pixel_palette     = r_o_pix.palette;
    assign o_pixel_from_sprite = r_o_pix.from_sprite;
    assign o_vblank_flag       = r_vblank;
    assign o_sprite_zero_hit   = r_zero_hit;
    assign o_nmi_pulse         = r_o_nmi;
    assign o_frame_end         = r_o_fend;
    assign o_fetch_step        = r_o_fetch;
    assign o_scroll_event      = r_o_scroll;

    a_nmi_in_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_nmi_pulse |-> o_vblank_flag)
        else $error("nmi raised outside vblank");

    a_pixel_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel_valid |-> (o_line >= vdt_pkg::LINE_FIRST)
            && (o_line <= vdt_pkg::LINE_VIS_LAST) && (o_dot >= vdt_pkg::DOT_FLAG)
            && (o_dot <= vdt_pkg::DOT_PIX_LAST))
        else $error("pixel outside visible window");

    a_frame_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> (o_line == vdt_pkg::LINE_LAST)
            && (o_dot == vdt_pkg::DOT_LAST))
        else $error("frame end at wrong dot");

    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dot <= vdt_pkg::DOT_LAST) && (r_line >= vdt_pkg::LINE_PRE)
            && (r_line <= vdt_pkg::LINE_LAST))
        else $error("dot counter out of range");

endmodule

>>> hw/rtl/vdt_pixel_mux.sv
`timescale 1ns / 1ps

module vdt_pixel_mux (
    input  vdt_pkg::t_tick               i_tick,
    input  logic signed [vdt_pkg::LINE_W-1:0] i_line,
    input  logic [vdt_pkg::DOT_W-1:0]    i_dot,
    output vdt_pkg::t_pix                o_pix
);

    logic       vis;
    logic       left;
    logic [1:0] bg;
    logic [1:0] spr;

    assign vis  = (i_line >= vdt_pkg::LINE_FIRST) && (i_line <= vdt_pkg::LINE_VIS_LAST)
                && (i_dot >= vdt_pkg::DOT_FLAG) && (i_dot <= vdt_pkg::DOT_PIX_LAST);
    assign left = (i_dot <= vdt_pkg::DOT_LEFT_LAST);

    // layer masked by its enable and the left-column clip
    assign bg  = (i_tick.bg_enable && (i_tick.bg_left_enable || !left))
               ? i_tick.bg_pixel : 2'd0;
    assign spr = (i_tick.spr_enable && (i_tick.spr_left_enable || !left))
               ? i_tick.spr_pixel : 2'd0;

    always_comb begin
        o_pix = '0;
        if (vis) begin
            o_pix.valid = 1'b1;
            priority if (bg == 2'd0 && spr == 2'd0) begin
                o_pix.value = 2'd0;
            end else if (bg == 2'd0 || (spr != 2'd0 && i_tick.spr_front)) begin
                o_pix.value       = spr;
                o_pix.palette     = i_tick.spr_palette;
                o_pix.from_sprite = 1'b1;
            end else begin
                o_pix.value   = bg;
                o_pix.palette = i_tick.bg_palette;
            end
            // rightmost pixel never registers a hit
            o_pix.zero_hit = (bg != 2'd0) && (spr != 2'd0) && i_tick.spr_is_zero
                           && i_tick.spr_zero_possible && (i_dot != vdt_pkg::DOT_PIX_LAST);
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TICK_W         = $bits(vdt_pkg::t_tick);
    localparam int DIRECTED_N     = 24;
    localparam int ITEMS_N        = 1950;
    localparam int CALM_FIRST     = 1200;
    localparam int CALM_LAST      = 1500;
    localparam int HIT_LINE_MAX   = 3;
    localparam int IDLE_PCT       = 27;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic signed [vdt_pkg::LINE_W-1:0] line;
        logic [vdt_pkg::DOT_W-1:0]         dot;
        logic                              pix_valid;
        logic [1:0]                        pix_value;
        logic [1:0]                        pix_palette;
        logic                              pix_sprite;
        logic                              vblank;
        logic                              zero_hit;
        logic                              nmi;
        logic                              frame_end;
        logic [2:0]                        fetch;
        logic [2:0]                        scroll;
    } t_dot_result;

    class dot_timing_scoreboard;
        logic signed [vdt_pkg::LINE_W-1:0] line_q  = vdt_pkg::LINE_PRE;
        logic [vdt_pkg::DOT_W-1:0]         dot_q   = vdt_pkg::DOT_FIRST;
        bit                                odd_q   = 1'b0;
        bit                                vblank_q = 1'b0;
        bit                                hit_q   = 1'b0;
        int unsigned                       frames  = 0;
        int unsigned                       errors  = 0;
        t_dot_result                       expected_q[$];

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_tick(vdt_pkg::t_tick t);
            t_dot_result r;
            bit          render, pre_line, vis_line, vis_dot, fetch_dot, left;
            logic [1:0]  b, s;
            r        = '0;
            r.line   = line_q;
            r.dot    = dot_q;
            render   = t.bg_enable | t.spr_enable;
            pre_line = (line_q == vdt_pkg::LINE_PRE);
            vis_line = (line_q >= vdt_pkg::LINE_FIRST) && (line_q <= vdt_pkg::LINE_VIS_LAST);
            vis_dot  = (dot_q >= vdt_pkg::DOT_FLAG) && (dot_q <= vdt_pkg::DOT_PIX_LAST);
            fetch_dot = vis_dot || ((dot_q >= vdt_pkg::DOT_PREF_FIRST) &&
                                    (dot_q <= vdt_pkg::DOT_PREF_LAST));

            if (pre_line && dot_q == vdt_pkg::DOT_FLAG) begin
                vblank_q = 1'b0;
                hit_q    = 1'b0;
            end
            if ((pre_line || vis_line) && render) begin
                if (fetch_dot) begin
                    case (dot_q[2:0])
                        3'd1:    r.fetch = vdt_pkg::FETCH_NAME;
                        3'd3:    r.fetch = vdt_pkg::FETCH_ATTR;
                        3'd5:    r.fetch = vdt_pkg::FETCH_PAT_LO;
                        3'd7:    r.fetch = vdt_pkg::FETCH_PAT_HI;
                        3'd0:    r.fetch = vdt_pkg::FETCH_LOAD;
                        default: r.fetch = vdt_pkg::FETCH_SHIFT;
                    endcase
                end
                if (dot_q == vdt_pkg::DOT_PIX_LAST)
                    r.scroll = vdt_pkg::SCROLL_INC_Y;
                else if (dot_q == vdt_pkg::DOT_COPY_X)
                    r.scroll = vdt_pkg::SCROLL_COPY_X;
                else if (pre_line && dot_q >= vdt_pkg::DOT_COPY_Y_LO &&
                         dot_q <= vdt_pkg::DOT_COPY_Y_HI)
                    r.scroll = vdt_pkg::SCROLL_COPY_Y;
                else if (vis_line && dot_q == vdt_pkg::DOT_HOOK)
                    r.scroll = vdt_pkg::SCROLL_HOOK;
            end
            if (line_q == vdt_pkg::LINE_VBLANK && dot_q == vdt_pkg::DOT_FLAG) begin
                vblank_q = 1'b1;
                r.nmi    = t.nmi_enable;
            end

            if (vis_line && vis_dot) begin
                left = (dot_q <= vdt_pkg::DOT_LEFT_LAST);
                b = (t.bg_enable && (t.bg_left_enable || !left)) ? t.bg_pixel : 2'd0;
                s = (t.spr_enable && (t.spr_left_enable || !left)) ? t.spr_pixel : 2'd0;
                r.pix_valid = 1'b1;
                if (s != 2'd0 && (b == 2'd0 || t.spr_front)) begin
                    r.pix_value   = s;
                    r.pix_palette = t.spr_palette;
                    r.pix_sprite  = 1'b1;
                end else if (b != 2'd0) begin
                    r.pix_value   = b;
                    r.pix_palette = t.bg_palette;
                end
                // the last pixel of the line never reports a hit
                if (b != 2'd0 && s != 2'd0 && t.spr_is_zero && t.spr_zero_possible &&
                    dot_q != vdt_pkg::DOT_PIX_LAST)
                    hit_q = 1'b1;
            end

            // odd frames drop the last dot of the pre-render line while rendering
            if (pre_line && dot_q == vdt_pkg::DOT_SKIP && odd_q && render) begin
                line_q = vdt_pkg::LINE_FIRST;
                dot_q  = vdt_pkg::DOT_FIRST;
            end else if (dot_q == vdt_pkg::DOT_LAST) begin
                dot_q = vdt_pkg::DOT_FIRST;
                if (line_q == vdt_pkg::LINE_LAST) begin
                    line_q      = vdt_pkg::LINE_PRE;
                    r.frame_end = 1'b1;
                    odd_q       = ~odd_q;
                    frames++;
                end else begin
                    line_q = line_q + 10'sd1;
                end
            end else begin
                dot_q = dot_q + 9'd1;
            end

            r.vblank   = vblank_q;
            r.zero_hit = hit_q;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string field, t_dot_result want, int exp_v, int got_v);
            if (exp_v != got_v) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch %s at line %0d dot %0d: expected %0d, got %0d",
                             field, want.line, want.dot, exp_v, got_v);
            end
        endfunction

        function void check_result(t_dot_result got);
            t_dot_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result at line %0d dot %0d", got.line, got.dot);
                return;
            end
            want = expected_q.pop_front();
            compare_field("line",              want, int'(want.line), int'(got.line));
            compare_field("dot",               want, int'(want.dot), int'(got.dot));
            compare_field("pixel_valid",       want, int'(want.pix_valid),
                          int'(got.pix_valid));
            compare_field("pixel_value",       want, int'(want.pix_value),
                          int'(got.pix_value));
            compare_field("pixel_palette",     want, int'(want.pix_palette),
                          int'(got.pix_palette));
            compare_field("pixel_from_sprite", want, int'(want.pix_sprite),
                          int'(got.pix_sprite));
            compare_field("vblank_flag",       want, int'(want.vblank), int'(got.vblank));
            compare_field("sprite_zero_hit",   want, int'(want.zero_hit),
                          int'(got.zero_hit));
            compare_field("nmi_pulse",         want, int'(want.nmi), int'(got.nmi));
            compare_field("frame_end",         want, int'(want.frame_end),
                          int'(got.frame_end));
            compare_field("fetch_step",        want, int'(want.fetch), int'(got.fetch));
            compare_field("scroll_event",      want, int'(want.scroll), int'(got.scroll));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    vdt_pkg::t_tick tick_q = '0;

    logic                              o_stall;
    logic                              o_valid;
    logic signed [vdt_pkg::LINE_W-1:0] o_line;
    logic [vdt_pkg::DOT_W-1:0]         o_dot;
    logic                              o_pixel_valid;
    logic [1:0]                        o_pixel_value;
    logic [1:0]                        o_pixel_palette;
    logic                              o_pixel_from_sprite;
    logic                              o_vblank_flag;
    logic                              o_sprite_zero_hit;
    logic                              o_nmi_pulse;
    logic                              o_frame_end;
    logic [2:0]                        o_fetch_step;
    logic [2:0]                        o_scroll_event;

    dot_timing_scoreboard sb = new;
    int unsigned ticks_sent = 0;
    bit          stim_done  = 1'b0;
    bit          dark_line  = 1'b0;
    int          hit_frame  = -1;
    int          hit_line   = 0;

    video_dot_timing_and_pixel_mux dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_bg_enable         (tick_q.bg_enable),
        .i_spr_enable        (tick_q.spr_enable),
        .i_bg_left_enable    (tick_q.bg_left_enable),
        .i_spr_left_enable   (tick_q.spr_left_enable),
        .i_nmi_enable        (tick_q.nmi_enable),
        .i_bg_pixel          (tick_q.bg_pixel),
        .i_bg_palette        (tick_q.bg_palette),
        .i_spr_pixel         (tick_q.spr_pixel),
        .i_spr_palette       (tick_q.spr_palette),
        .i_spr_front         (tick_q.spr_front),
        .i_spr_is_zero       (tick_q.spr_is_zero),
        .i_spr_zero_possible (tick_q.spr_zero_possible),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_line              (o_line),
        .o_dot               (o_dot),
        .o_pixel_valid       (o_pixel_valid),
        .o_pixel_value       (o_pixel_value),
        .o_pixel_palette     (o_pixel_palette),
        .o_pixel_from_sprite (o_pixel_from_sprite),
        .o_vblank_flag       (o_vblank_flag),
        .o_sprite_zero_hit   (o_sprite_zero_hit),
        .o_nmi_pulse         (o_nmi_pulse),
        .o_frame_end         (o_frame_end),
        .o_fetch_step        (o_fetch_step),
        .o_scroll_event      (o_scroll_event)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // a window of items in which neither side idles
    function automatic bit in_calm();
        return (ticks_sent >= CALM_FIRST) && (ticks_sent < CALM_LAST);
    endfunction

    // picks the next tick from the dot it will land on
    function automatic vdt_pkg::t_tick make_tick();
        vdt_pkg::t_tick                    t;
        logic [TICK_W-1:0]                 bits;
        logic signed [vdt_pkg::LINE_W-1:0] ln;
        logic [vdt_pkg::DOT_W-1:0]         dt;
        ln = sb.line_q;
        dt = sb.dot_q;

        if (ticks_sent < DIRECTED_N) begin
            // all clear, all set, then a walking zero, then a few random
            bits = '0;
            if (ticks_sent == 1)
                bits = '1;
            else if (ticks_sent >= 2 && ticks_sent < 2 + TICK_W) begin
                bits[ticks_sent - 2] = 1'b1;
                bits = ~bits;
            end else if (ticks_sent >= 2)
                bits = TICK_W'($urandom);
            return vdt_pkg::t_tick'(bits);
        end

        if (int'(sb.frames) != hit_frame) begin
            hit_frame = int'(sb.frames);
            hit_line  = int'($urandom_range(0, HIT_LINE_MAX));
        end
        if (dt == vdt_pkg::DOT_FIRST)
            dark_line = ($urandom_range(0, 15) == 0);

        t.bg_enable         = !dark_line && ($urandom_range(0, 9) != 0);
        t.spr_enable        = !dark_line && ($urandom_range(0, 9) != 0);
        t.bg_left_enable    = 1'($urandom_range(0, 1));
        t.spr_left_enable   = 1'($urandom_range(0, 1));
        t.nmi_enable        = 1'($urandom_range(0, 1));
        t.bg_pixel          = 2'($urandom_range(0, 3));
        t.bg_palette        = 2'($urandom_range(0, 3));
        t.spr_pixel         = 2'($urandom_range(0, 3));
        t.spr_palette       = 2'($urandom_range(0, 3));
        t.spr_front         = 1'($urandom_range(0, 1));
        t.spr_zero_possible = 1'($urandom_range(0, 1));
        // sprite zero kept away until a chosen line, bar the rightmost pixel, so the first hit is visible
        t.spr_is_zero = (ln >= hit_line) && ($urandom_range(0, 7) == 0);

        if (ln >= vdt_pkg::LINE_FIRST && ln < hit_line && dt == vdt_pkg::DOT_PIX_LAST) begin
            t.bg_enable         = 1'b1;
            t.spr_enable        = 1'b1;
            t.bg_pixel          = 2'($urandom_range(1, 3));
            t.spr_pixel         = 2'($urandom_range(1, 3));
            t.spr_is_zero       = 1'b1;
            t.spr_zero_possible = 1'b1;
        end
        if (ln == vdt_pkg::LINE_VBLANK && dt == vdt_pkg::DOT_FLAG)
            t.nmi_enable = (sb.frames % 2 == 0);
        // one odd frame skips on sprites alone, the other renders nothing at the skip dot
        if (ln == vdt_pkg::LINE_PRE && dt == vdt_pkg::DOT_SKIP && sb.frames == 1) begin
            t.bg_enable  = 1'b0;
            t.spr_enable = 1'b1;
        end else if (ln == vdt_pkg::LINE_PRE && dt == vdt_pkg::DOT_SKIP && sb.frames == 3) begin
            t.bg_enable  = 1'b0;
            t.spr_enable = 1'b0;
        end
        return t;
    endfunction

    task automatic drive_ticks();
        while (!stim_done) begin
            @(posedge i_clk);
            if (i_valid && !o_stall) begin
                sb.note_tick(tick_q);
                ticks_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (ticks_sent >= ITEMS_N) begin
                    stim_done = 1'b1;
                    i_valid  <= 1'b0;
                end else if ((ticks_sent == DIRECTED_N && sb.pending() != 0) ||
                             (!in_calm() && $urandom_range(0, 99) < IDLE_PCT)) begin
                    i_valid <= 1'b0;
                end else begin
                    tick_q  <= make_tick();
                    i_valid <= 1'b1;
                end
            end
        end
    endtask

    initial begin
        t_dot_result got;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got.line        = o_line;
                got.dot         = o_dot;
                got.pix_valid   = o_pixel_valid;
                got.pix_value   = o_pixel_value;
                got.pix_palette = o_pixel_palette;
                got.pix_sprite  = o_pixel_from_sprite;
                got.vblank      = o_vblank_flag;
                got.zero_hit    = o_sprite_zero_hit;
                got.nmi         = o_nmi_pulse;
                got.frame_end   = o_frame_end;
                got.fetch       = o_fetch_step;
                got.scroll      = o_scroll_event;
                sb.check_result(got);
            end
            i_stall <= !in_calm() && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_ticks();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
